// File: rtl/pit_pkg.sv
// Package for the point-in-tetrahedron test unit: widths, types, opcodes.
// No dependencies.
`default_nettype none
package pit_pkg;
    localparam int NodeBits  = 12;
    localparam int CoordBits = 24;
    localparam int DiffBits  = CoordBits + 1;
    localparam int MinBits   = 2 * DiffBits + 1;
    localparam int DetBits   = MinBits + DiffBits + 2;
    localparam int SplitBits = 26;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;
    typedef logic [NodeBits-1:0] t_node;
    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0] t_diff;
    typedef logic signed [MinBits-1:0] t_minor;
    typedef logic signed [DetBits-1:0] t_det;
    typedef logic signed [SplitBits+DiffBits:0] t_plo;
    typedef logic signed [MinBits-SplitBits+DiffBits-1:0] t_phi;
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;
    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;
endpackage
`default_nettype wire

// File: rtl/pit_fetch.sv
// Vertex table and sequencer: stores vertices, reads the four corners of a test.
// Depends on pit_pkg.
`default_nettype none
module pit_fetch (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_operation,
    input  pit_pkg::t_node     i_node_index,
    input  pit_pkg::t_vec      i_pt,
    input  pit_pkg::t_node     i_va,
    input  pit_pkg::t_node     i_vb,
    input  pit_pkg::t_node     i_vc,
    input  pit_pkg::t_node     i_vd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pit_pkg::t_dvec     o_u,
    output pit_pkg::t_dvec     o_v,
    output pit_pkg::t_dvec     o_w,
    output pit_pkg::t_dvec     o_p
);
    import pit_pkg::*;

    t_vec  r_mem [0:(1<<NodeBits)-1];
    t_vec  r_rd;
    logic  r_busy;
    logic [2:0] r_step;
    t_node r_idx [0:3];
    t_vec  r_pt;
    t_vec  r_c [0:2];
    logic  r_valid;
    t_dvec r_u, r_v, r_w, r_p;
    t_node n_addr;

    function automatic t_dvec f_sub(t_vec a, t_vec b);
        t_dvec r;
        r.x = t_diff'(a.x) - t_diff'(b.x);
        r.y = t_diff'(a.y) - t_diff'(b.y);
        r.z = t_diff'(a.z) - t_diff'(b.z);
        return r;
    endfunction

    assign o_ready = !r_busy && (!r_valid || i_ready);
    assign n_addr  = r_idx[r_step[1:0]];

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && i_operation == OP_WRITE) begin
            r_mem[i_node_index] <= i_pt;
        end
        r_rd <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            if (o_ready && i_valid && i_operation == OP_TEST) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_idx[0] <= i_va;
            r_idx[1] <= i_vb;
            r_idx[2] <= i_vc;
            r_idx[3] <= i_vd;
            r_pt     <= i_pt;
        end
        if (r_busy) begin
            if (r_step >= 3'd1 && r_step <= 3'd3) r_c[r_step[1:0] - 2'd1] <= r_rd;
            if (r_step == 3'd4) begin
                r_u <= f_sub(r_c[0], r_rd);
                r_v <= f_sub(r_c[1], r_rd);
                r_w <= f_sub(r_c[2], r_rd);
                r_p <= f_sub(r_pt, r_rd);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_u = r_u;
    assign o_v = r_v;
    assign o_w = r_w;
    assign o_p = r_p;
endmodule
`default_nettype wire

// File: rtl/pit_solve.sv
// Determinant pipeline: minors, split cofactor products, sums and final compare.
// Depends on pit_pkg.
`default_nettype none
module pit_solve (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  pit_pkg::t_dvec i_u,
    input  pit_pkg::t_dvec i_v,
    input  pit_pkg::t_dvec i_w,
    input  pit_pkg::t_dvec i_p,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic           o_inside_res,
    output logic           o_degenerate
);
    import pit_pkg::*;

    logic   adv;
    logic   r_v1, r_v2, r_v3, r_v4, r_v5;
    t_minor r_m [0:8];
    t_dvec  r_u1, r_p1;
    t_minor mul_m [0:11];
    t_diff  mul_d [0:11];
    t_phi   r_ph [0:11];
    t_plo   r_pl [0:11];
    t_det   r_t [0:11];
    t_det   r_det, r_n1, r_n2, r_n3;
    logic   r_ins, r_deg;

    function automatic t_minor f_m(t_diff a, t_diff b, t_diff c, t_diff d);
        return (t_minor'(a) * t_minor'(d)) - (t_minor'(b) * t_minor'(c));
    endfunction

    function automatic t_plo f_lo(t_minor m, t_diff d);
        logic signed [SplitBits:0] a;
        a = {1'b0, m[SplitBits-1:0]};
        return t_plo'(a) * t_plo'(d);
    endfunction

    function automatic t_phi f_hi(t_minor m, t_diff d);
        return t_phi'($signed(m[MinBits-1:SplitBits])) * t_phi'(d);
    endfunction

    function automatic t_det f_join(t_phi h, t_plo l);
        return (t_det'(h) <<< SplitBits) + t_det'(l);
    endfunction

    assign adv = !r_v5 || i_ready;
    assign o_ready = adv;

    always_comb begin
        mul_m[0]  = r_m[0]; mul_d[0]  = r_u1.x;
        mul_m[1]  = r_m[1]; mul_d[1]  = r_u1.y;
        mul_m[2]  = r_m[2]; mul_d[2]  = r_u1.z;
        mul_m[3]  = r_m[0]; mul_d[3]  = r_p1.x;
        mul_m[4]  = r_m[1]; mul_d[4]  = r_p1.y;
        mul_m[5]  = r_m[2]; mul_d[5]  = r_p1.z;
        mul_m[6]  = r_m[3]; mul_d[6]  = r_u1.x;
        mul_m[7]  = r_m[4]; mul_d[7]  = r_u1.y;
        mul_m[8]  = r_m[5]; mul_d[8]  = r_u1.z;
        mul_m[9]  = r_m[6]; mul_d[9]  = r_u1.x;
        mul_m[10] = r_m[7]; mul_d[10] = r_u1.y;
        mul_m[11] = r_m[8]; mul_d[11] = r_u1.z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0] <= f_m(i_v.y, i_w.y, i_v.z, i_w.z);
            r_m[1] <= f_m(i_v.x, i_w.x, i_v.z, i_w.z);
            r_m[2] <= f_m(i_v.x, i_w.x, i_v.y, i_w.y);
            r_m[3] <= f_m(i_p.y, i_w.y, i_p.z, i_w.z);
            r_m[4] <= f_m(i_p.x, i_w.x, i_p.z, i_w.z);
            r_m[5] <= f_m(i_p.x, i_w.x, i_p.y, i_w.y);
            r_m[6] <= f_m(i_v.y, i_p.y, i_v.z, i_p.z);
            r_m[7] <= f_m(i_v.x, i_p.x, i_v.z, i_p.z);
            r_m[8] <= f_m(i_v.x, i_p.x, i_v.y, i_p.y);
            r_u1 <= i_u;
            r_p1 <= i_p;
            for (int k = 0; k < 12; k++) begin
                r_ph[k] <= f_hi(mul_m[k], mul_d[k]);
                r_pl[k] <= f_lo(mul_m[k], mul_d[k]);
                r_t[k]  <= f_join(r_ph[k], r_pl[k]);
            end
            r_det <= r_t[0] - r_t[1] + r_t[2];
            r_n1  <= r_t[3] - r_t[4] + r_t[5];
            r_n2  <= r_t[6] - r_t[7] + r_t[8];
            r_n3  <= r_t[9] - r_t[10] + r_t[11];
            r_deg <= (r_det == '0);
            if (r_det[DetBits-1]) begin
                r_ins <= (r_det != '0) && !(r_n1 > 0) && !(r_n2 > 0) && !(r_n3 > 0)
                         && (r_n1 + r_n2 + r_n3 >= r_det);
            end else begin
                r_ins <= (r_det != '0) && !r_n1[DetBits-1] && !r_n2[DetBits-1]
                         && !r_n3[DetBits-1] && (r_n1 + r_n2 + r_n3 <= r_det);
            end
        end
    end

    assign o_valid      = r_v5;
    assign o_inside_res = r_ins;
    assign o_degenerate = r_deg;
endmodule
`default_nettype wire

// File: rtl/point_in_tetrahedron_test_unit.sv
// Top level of the point-in-tetrahedron test unit.
// Depends on pit_pkg, pit_fetch and pit_solve.
//
// Input channel (i_valid/o_ready): an operation 0 item writes vertex
// (coord_x, coord_y, coord_z) into table slot node_index and gives no
// result. An operation 1 item tests point (coord_x..z) against the
// tetrahedron with corners vertex_a..vertex_d and gives one result.
// Output channel (o_valid/i_ready): inside_res and degenerate.
// A test occupies the vertex table for its four reads plus the difference
// stage, and no new item is accepted until it is done. The determinant
// pipeline has five stages: minors, split partial products, cofactor
// products, sums, sign and range compare. Reset clears all valid and busy
// flags; the table is undefined until written. When the receiver stalls
// the pipeline holds and the input side stops accepting once the fetch
// output is full.
`default_nettype none
module point_in_tetrahedron_test_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_operation,
    input  wire logic [11:0] i_node_index,
    input  wire logic signed [23:0] i_coord_x,
    input  wire logic signed [23:0] i_coord_y,
    input  wire logic signed [23:0] i_coord_z,
    input  wire logic [11:0] i_vertex_a,
    input  wire logic [11:0] i_vertex_b,
    input  wire logic [11:0] i_vertex_c,
    input  wire logic [11:0] i_vertex_d,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_inside_res,
    output logic            o_degenerate
);
    import pit_pkg::*;

    t_vec  pt;
    t_dvec u, v, w, p;
    logic  f_valid, s_ready;

    assign pt.x = i_coord_x;
    assign pt.y = i_coord_y;
    assign pt.z = i_coord_z;

    pit_fetch u_fetch (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation,
        .i_node_index, .i_pt(pt),
        .i_va(i_vertex_a), .i_vb(i_vertex_b), .i_vc(i_vertex_c), .i_vd(i_vertex_d),
        .o_valid(f_valid), .i_ready(s_ready),
        .o_u(u), .o_v(v), .o_w(w), .o_p(p)
    );

    pit_solve u_solve (
        .i_clk, .i_rst_n, .i_valid(f_valid && s_ready), .o_ready(s_ready),
        .i_u(u), .i_v(v), .i_w(w), .i_p(p),
        .o_valid, .i_ready, .o_inside_res, .o_degenerate
    );
endmodule
`default_nettype wire

// File: test/pit_checker.sv
`timescale 1ns / 1ps
// Checker for the point-in-tetrahedron test unit: watches both channels, keeps its own
// vertex table, predicts each test outcome and compares. Depends on pit_pkg.
module pit_checker
    import pit_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   i_ready_in,
    input  wire logic   i_operation,
    input  wire t_node  i_node_index,
    input  wire t_coord i_coord_x,
    input  wire t_coord i_coord_y,
    input  wire t_coord i_coord_z,
    input  wire t_node  i_vertex_a,
    input  wire t_node  i_vertex_b,
    input  wire t_node  i_vertex_c,
    input  wire t_node  i_vertex_d,
    input  wire logic   i_out_valid,
    input  wire logic   i_out_ready,
    input  wire logic   i_inside_res,
    input  wire logic   i_degenerate,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_lvec;

    typedef struct {
        logic hit;
        logic degen;
    } t_outcome;

    t_vec     mesh_nodes [1 << NodeBits];
    t_outcome outcome_q [$];

    function automatic logic signed [127:0] det3(t_lvec c0, t_lvec c1, t_lvec c2);
        logic signed [127:0] m0, m1, m2;
        m0 = c1.y * c2.z - c2.y * c1.z;
        m1 = c1.x * c2.z - c2.x * c1.z;
        m2 = c1.x * c2.y - c2.x * c1.y;
        return m0 * c0.x - m1 * c0.y + m2 * c0.z;
    endfunction

    function automatic t_lvec diff(t_vec a, t_vec d);
        t_lvec r;
        r.x = longint'(a.x) - longint'(d.x);
        r.y = longint'(a.y) - longint'(d.y);
        r.z = longint'(a.z) - longint'(d.z);
        return r;
    endfunction

    function automatic t_outcome containment(t_vec pt, t_vec a, t_vec b, t_vec c, t_vec d);
        t_lvec u, v, w, p;
        logic signed [127:0] det, n1, n2, n3;
        t_outcome r;
        u = diff(a, d);
        v = diff(b, d);
        w = diff(c, d);
        p = diff(pt, d);
        det = det3(u, v, w);
        r.degen = (det == 0);
        r.hit = 1'b0;
        if (!r.degen) begin
            n1 = det3(p, v, w);
            n2 = det3(u, p, w);
            n3 = det3(u, v, p);
            if (det < 0) begin
                det = -det;
                n1 = -n1;
                n2 = -n2;
                n3 = -n3;
            end
            r.hit = (n1 >= 0) && (n2 >= 0) && (n3 >= 0) && (det - n1 - n2 - n3 >= 0);
        end
        return r;
    endfunction

    assign o_pending = outcome_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_vec     pt;
        t_outcome got;
        if (i_rst_n && i_valid && i_ready_in) begin
            pt = '{i_coord_x, i_coord_y, i_coord_z};
            if (i_operation == OP_WRITE) begin
                mesh_nodes[i_node_index] = pt;
            end else begin
                outcome_q = {outcome_q, containment(pt, mesh_nodes[i_vertex_a],
                    mesh_nodes[i_vertex_b], mesh_nodes[i_vertex_c], mesh_nodes[i_vertex_d])};
            end
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result item");
                o_fail_count = o_fail_count + 1;
            end else begin
                got = outcome_q.pop_front();
                if (i_inside_res !== got.hit) begin
                    $error("inside_res expected %0d actual %0d", got.hit, i_inside_res);
                    o_fail_count = o_fail_count + 1;
                end
                if (i_degenerate !== got.degen) begin
                    $error("degenerate expected %0d actual %0d", got.degen, i_degenerate);
                    o_fail_count = o_fail_count + 1;
                end
            end
        end
    end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for point_in_tetrahedron_test_unit: drives writes and tests with random
// gaps and stalls, gives the verdict. Depends on pit_pkg, pit_checker and the RTL.
module tb;
    import pit_pkg::*;

    localparam int CycleLimit = 500000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    logic   i_operation = OP_WRITE;
    t_node  i_node_index = '0;
    t_coord i_coord_x = '0;
    t_coord i_coord_y = '0;
    t_coord i_coord_z = '0;
    t_node  i_vertex_a = '0;
    t_node  i_vertex_b = '0;
    t_node  i_vertex_c = '0;
    t_node  i_vertex_d = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    logic   o_inside_res;
    logic   o_degenerate;
    int     fail_count;
    int     pending;
    int     cycle_count = 0;
    int     results_taken = 0;
    bit     burst_mode = 0;
    bit     is_written [1 << NodeBits];
    t_node  written_slots [$];
    t_vec   shadow [1 << NodeBits];

    point_in_tetrahedron_test_unit dut (.*);

    pit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_operation(i_operation), .i_node_index(i_node_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b), .i_vertex_c(i_vertex_c),
        .i_vertex_d(i_vertex_d), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_inside_res(o_inside_res), .i_degenerate(o_degenerate),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("point_in_tetrahedron_test_unit verification failed");
            $finish;
        end
    end

    task automatic offer(logic op, t_node idx, t_vec pt, t_node a, t_node b, t_node c, t_node d);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation = op;
        i_node_index = idx;
        i_coord_x = pt.x;
        i_coord_y = pt.y;
        i_coord_z = pt.z;
        i_vertex_a = a;
        i_vertex_b = b;
        i_vertex_c = c;
        i_vertex_d = d;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic store_vertex(t_node idx, t_vec pt);
        if (!is_written[idx]) written_slots = {written_slots, idx};
        is_written[idx] = 1;
        shadow[idx] = pt;
        offer(OP_WRITE, idx, pt, t_node'($urandom), t_node'($urandom),
              t_node'($urandom), t_node'($urandom));
    endtask

    task automatic probe(t_vec pt, t_node a, t_node b, t_node c, t_node d);
        offer(OP_TEST, t_node'($urandom), pt, a, b, c, d);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic t_node pick_slot();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    function automatic t_vec rand_vec();
        return '{t_coord'($urandom), t_coord'($urandom), t_coord'($urandom)};
    endfunction

    // query point for the tetrahedron: random point, corner, edge midpoint, centroid or noisy centroid
    function automatic t_vec query_for(t_node a, t_node b, t_node c, t_node d);
        t_vec   pa, pb, pc, pd, r;
        longint sx, sy, sz;
        int     noise;
        pa = shadow[a];
        pb = shadow[b];
        pc = shadow[c];
        pd = shadow[d];
        sx = longint'(pa.x) + pb.x + pc.x + pd.x;
        sy = longint'(pa.y) + pb.y + pc.y + pd.y;
        sz = longint'(pa.z) + pb.z + pc.z + pd.z;
        noise = $urandom_range(0, 64);
        case ($urandom_range(0, 5))
            0: r = rand_vec();
            1: r = pa;
            2: r = '{t_coord'((longint'(pa.x) + pb.x) >>> 1),
                     t_coord'((longint'(pa.y) + pb.y) >>> 1),
                     t_coord'((longint'(pa.z) + pb.z) >>> 1)};
            3: r = '{t_coord'((sx + $signed(noise) - 32) / 4),
                     t_coord'((sy - $signed(noise) + 32) / 4), t_coord'(sz / 4)};
            default: r = '{t_coord'(sx / 4), t_coord'(sy / 4), t_coord'(sz / 4)};
        endcase
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (results_taken == 300) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                results_taken = results_taken + 1;
            end
            if (burst_mode || $urandom_range(0, 14) == 0) begin
                i_ready = 1'b1;
            end else begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_ready = 1'b1;
            end
            do @(posedge i_clk); while (!o_valid);
            results_taken = results_taken + 1;
        end
    end

    initial begin
        t_vec  corner;
        t_node a, b, c, d;
        int    sent;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        store_vertex(12'd0, '{24'sd0, 24'sd0, 24'sd0});
        store_vertex(12'd1, '{24'sd1000, 24'sd0, 24'sd0});
        store_vertex(12'd2, '{24'sd0, 24'sd1000, 24'sd0});
        store_vertex(12'd3, '{24'sd0, 24'sd0, 24'sd1000});
        store_vertex(12'd4095, '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        store_vertex(12'd4094, '{24'sh800000, 24'sh800000, 24'sh800000});
        store_vertex(12'd4093, '{24'sh7FFFFF, 24'sh800000, 24'sd0});
        probe('{24'sd100, 24'sd100, 24'sd100}, 12'd1, 12'd2, 12'd3, 12'd0);
        probe('{24'sd500, 24'sd500, 24'sd0}, 12'd1, 12'd2, 12'd3, 12'd0);
        probe('{24'sd501, 24'sd500, 24'sd0}, 12'd1, 12'd2, 12'd3, 12'd0);
        probe('{-24'sd1, 24'sd0, 24'sd0}, 12'd1, 12'd2, 12'd3, 12'd0);
        probe('{24'sd1000, 24'sd0, 24'sd0}, 12'd2, 12'd1, 12'd3, 12'd0);
        probe('{24'sd0, 24'sd0, 24'sd0}, 12'd1, 12'd1, 12'd3, 12'd0);
        probe('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 12'd4095, 12'd4094, 12'd4093, 12'd1);
        probe('{24'sh800000, 24'sh800000, 24'sh800000}, 12'd4094, 12'd4093, 12'd4095, 12'd2);
        probe('{24'sd0, 24'sd0, 24'sd0}, 12'd4095, 12'd4094, 12'd0, 12'd3);
        probe('{24'sh7FFFFF, 24'sh800000, 24'sd5}, 12'd4093, 12'd0, 12'd4095, 12'd4094);
        probe('{24'sd10, 24'sd10, 24'sd10}, 12'd0, 12'd4095, 12'd4094, 12'd1);
        drain();

        sent = 0;
        while (sent < 1800) begin
            burst_mode = ((sent / 150) % 4 == 3);
            if (sent == 900) drain();
            if ($urandom_range(0, 3) == 0) begin
                // a fresh small cluster followed by tests against it
                corner = rand_vec();
                a = t_node'($urandom);
                b = t_node'($urandom);
                c = t_node'($urandom);
                d = t_node'($urandom);
                store_vertex(a, corner);
                store_vertex(b, '{corner.x + t_coord'($urandom_range(0, 255)), corner.y,
                                  corner.z - t_coord'($urandom_range(0, 255))});
                store_vertex(c, '{corner.x, corner.y + t_coord'($urandom_range(0, 255)),
                                  corner.z});
                store_vertex(d, '{corner.x - t_coord'($urandom_range(0, 255)), corner.y,
                                  corner.z + t_coord'($urandom_range(0, 255))});
                sent += 4;
                repeat ($urandom_range(1, 4)) begin
                    probe(query_for(a, b, c, d), a, b, c, d);
                    sent++;
                end
            end else if ($urandom_range(0, 4) == 0) begin
                store_vertex(t_node'($urandom), rand_vec());
                sent++;
            end else begin
                a = pick_slot();
                b = pick_slot();
                c = pick_slot();
                d = pick_slot();
                probe(query_for(a, b, c, d), a, b, c, d);
                sent++;
            end
        end
        burst_mode = 0;
        drain();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("point_in_tetrahedron_test_unit verification clean");
        end else begin
            $display("point_in_tetrahedron_test_unit verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/pit_pkg.sv
rtl/pit_fetch.sv
rtl/pit_solve.sv
rtl/point_in_tetrahedron_test_unit.sv
test/pit_checker.sv
test/tb.sv
